@@ rtl/tcw_pkg.sv @@
// Shared types and constants for the text console writer.
// Holds the request/response payload structs, command codes and FSM states.
// No dependencies.
`default_nettype none

package tcw_pkg;

  localparam int DEF_COLS = 80;
  localparam int DEF_ROWS = 25;

  localparam int CELL_W    = 16;
  localparam int CHAR_W    = 8;
  localparam int COLOR_W   = 8;
  localparam int SCROLL_W  = 5;
  localparam int IDX_W     = 11;
  localparam int COLF_W    = 7;
  localparam int ROWF_W    = 5;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_LINES = 1'b1;

  localparam logic [CHAR_W-1:0]   LINE_FEED    = 8'd10;
  localparam logic [CHAR_W-1:0]   BLANK_CHAR   = 8'd32;
  localparam logic [COLOR_W-1:0]  RESET_COLOR  = 8'h07;
  localparam logic [SCROLL_W-1:0] RESET_SCROLL = 5'd1;
  localparam logic [CELL_W-1:0]   RESET_CELL   = {RESET_COLOR, BLANK_CHAR};

  typedef struct packed {
    logic [1:0]       cmd;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0] cell_index;
  } req_t;

  typedef struct packed {
    logic [COLF_W-1:0] cursor_col;
    logic [ROWF_W-1:0] cursor_row;
    logic [CELL_W-1:0] cell_data;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_FILL
  } state_t;

endpackage

`default_nettype wire

@@ rtl/tcw_screen_ram.sv @@
// Screen store: simple dual-port RAM, one write and one registered read per cycle.
// Uses tcw_pkg for the cell width.
`default_nettype none

module tcw_screen_ram #(
  parameter int DEPTH = tcw_pkg::DEF_COLS * tcw_pkg::DEF_ROWS
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [$clog2(DEPTH)-1:0]    waddr,
  input  wire logic [tcw_pkg::CELL_W-1:0]  wdata,
  input  wire logic [$clog2(DEPTH)-1:0]    raddr,
  output logic      [tcw_pkg::CELL_W-1:0]  rdata
);

  logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/tcw_ctrl.sv @@
// Command sequencer: cursor, put/read handling and the copy/fill sweeps over the screen RAM.
// Uses tcw_pkg; drives the ports of tcw_screen_ram.
`default_nettype none

module tcw_ctrl #(
  parameter int COLS = tcw_pkg::DEF_COLS,
  parameter int ROWS = tcw_pkg::DEF_ROWS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire tcw_pkg::req_t                   req,
  input  wire logic [tcw_pkg::COLOR_W-1:0]     text_color,
  input  wire logic [tcw_pkg::SCROLL_W-1:0]    scroll_lines,
  output logic                                 busy,
  output logic                                 done,
  output tcw_pkg::rsp_t                        rsp,
  output logic                                 mem_we,
  output logic [$clog2(COLS*ROWS)-1:0]         mem_waddr,
  output logic [tcw_pkg::CELL_W-1:0]           mem_wdata,
  output logic [$clog2(COLS*ROWS)-1:0]         mem_raddr,
  input  wire logic [tcw_pkg::CELL_W-1:0]      mem_rdata
);

  localparam int CELLS  = COLS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int COL_W  = $clog2(COLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int EXT_W  = (CNT_W > tcw_pkg::IDX_W) ? CNT_W : tcw_pkg::IDX_W;
  localparam int SCR_W  = (ROW_W + 1 > tcw_pkg::SCROLL_W) ? ROW_W + 1 : tcw_pkg::SCROLL_W;

  tcw_pkg::state_t state, state_next;

  logic [COL_W-1:0]           cur_col, cur_col_next;
  logic [ROW_W-1:0]           cur_row, cur_row_next;
  logic [CNT_W-1:0]           idx, idx_next;
  logic [CNT_W-1:0]           src_off, src_off_next;
  logic [CNT_W-1:0]           copy_len, copy_len_next;
  logic                       pend, pend_next;
  logic [ADDR_W-1:0]          pend_addr, pend_addr_next;
  logic [tcw_pkg::CELL_W-1:0] fill_cell, fill_cell_next;
  logic                       fill_report, fill_report_next;
  logic                       rd_ok, rd_ok_next;
  logic                       done_next;
  logic [tcw_pkg::CELL_W-1:0] rsp_data, rsp_data_next;

  logic [CNT_W-1:0]           lin_full;
  logic [EXT_W-1:0]           idx_ext;
  logic [SCR_W-1:0]           sl_ext;
  logic [SCR_W-1:0]           scroll_d;
  logic [CNT_W-1:0]           off_calc;
  logic [CNT_W-1:0]           src_full;
  logic [tcw_pkg::CELL_W-1:0] blank_cell;

  always_comb begin
    lin_full   = CNT_W'(cur_row) * CNT_W'(COLS) + CNT_W'(cur_col);
    idx_ext    = EXT_W'(req.cell_index);
    sl_ext     = SCR_W'(scroll_lines);
    if (sl_ext == '0) begin
      scroll_d = SCR_W'(1);
    end else if (sl_ext > SCR_W'(ROWS)) begin
      scroll_d = SCR_W'(ROWS);
    end else begin
      scroll_d = sl_ext;
    end
    off_calc   = CNT_W'(scroll_d) * CNT_W'(COLS);
    src_full   = idx + src_off;
    blank_cell = {text_color, tcw_pkg::BLANK_CHAR};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= tcw_pkg::ST_FILL;   // clearing pass after reset
      cur_col     <= '0;
      cur_row     <= '0;
      idx         <= '0;
      pend        <= 1'b0;
      fill_cell   <= tcw_pkg::RESET_CELL;
      fill_report <= 1'b0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      cur_col     <= cur_col_next;
      cur_row     <= cur_row_next;
      idx         <= idx_next;
      pend        <= pend_next;
      fill_cell   <= fill_cell_next;
      fill_report <= fill_report_next;
      done        <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    src_off   <= src_off_next;
    copy_len  <= copy_len_next;
    pend_addr <= pend_addr_next;
    rd_ok     <= rd_ok_next;
    rsp_data  <= rsp_data_next;
  end

  always_comb begin
    state_next       = state;
    cur_col_next     = cur_col;
    cur_row_next     = cur_row;
    idx_next         = idx;
    src_off_next     = src_off;
    copy_len_next    = copy_len;
    pend_next        = pend;
    pend_addr_next   = pend_addr;
    fill_cell_next   = fill_cell;
    fill_report_next = fill_report;
    rd_ok_next       = rd_ok;
    done_next        = 1'b0;
    rsp_data_next    = rsp_data;
    mem_we           = 1'b0;
    mem_waddr        = pend_addr;
    mem_wdata        = mem_rdata;
    mem_raddr        = '0;

    case (state)
      tcw_pkg::ST_IDLE: begin
        if (start) begin
          rsp_data_next = '0;
          case (req.cmd)
            tcw_pkg::CMD_PUT: begin
              logic wrap;
              wrap = 1'b1;
              if (req.char_code != tcw_pkg::LINE_FEED) begin
                mem_we    = 1'b1;
                mem_waddr = lin_full[ADDR_W-1:0];
                mem_wdata = {text_color, req.char_code};
                wrap      = (cur_col == COL_W'(COLS - 1));
                if (!wrap) begin
                  cur_col_next = cur_col + COL_W'(1);
                end
              end
              if (!wrap) begin
                done_next = 1'b1;
              end else if (cur_row == ROW_W'(ROWS - 1)) begin
                // bottom passed: copy rows up, then blank the freed rows
                cur_col_next     = '0;
                cur_row_next     = ROW_W'(ROWS) - ROW_W'(scroll_d);
                src_off_next     = off_calc;
                copy_len_next    = CNT_W'(CELLS) - off_calc;
                idx_next         = '0;
                pend_next        = 1'b0;
                fill_cell_next   = blank_cell;
                fill_report_next = 1'b1;
                state_next       = tcw_pkg::ST_COPY;
              end else begin
                cur_col_next = '0;
                cur_row_next = cur_row + ROW_W'(1);
                done_next    = 1'b1;
              end
            end
            tcw_pkg::CMD_READ: begin
              mem_raddr  = idx_ext[ADDR_W-1:0];
              rd_ok_next = (idx_ext < EXT_W'(CELLS));
              state_next = tcw_pkg::ST_READ;
            end
            tcw_pkg::CMD_CLEAR: begin
              idx_next         = '0;
              fill_cell_next   = blank_cell;
              fill_report_next = 1'b1;
              state_next       = tcw_pkg::ST_FILL;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      tcw_pkg::ST_READ: begin
        done_next     = 1'b1;
        rsp_data_next = rd_ok ? mem_rdata : '0;
        state_next    = tcw_pkg::ST_IDLE;
      end

      tcw_pkg::ST_COPY: begin
        // read runs one entry ahead of the write; the source address is always above the destination
        if (pend) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr;
          mem_wdata = mem_rdata;
        end
        if (idx < copy_len) begin
          mem_raddr      = src_full[ADDR_W-1:0];
          pend_next      = 1'b1;
          pend_addr_next = idx[ADDR_W-1:0];
          idx_next       = idx + CNT_W'(1);
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            state_next = tcw_pkg::ST_FILL;
          end
        end
      end

      tcw_pkg::ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = idx[ADDR_W-1:0];
        mem_wdata = fill_cell;
        idx_next  = idx + CNT_W'(1);
        if (idx == CNT_W'(CELLS - 1)) begin
          state_next    = tcw_pkg::ST_IDLE;
          done_next     = fill_report;
          rsp_data_next = '0;
        end
      end

      default: begin
        state_next = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy           = (state != tcw_pkg::ST_IDLE);
  assign rsp.cursor_col = tcw_pkg::COLF_W'(cur_col);
  assign rsp.cursor_row = tcw_pkg::ROWF_W'(cur_row);
  assign rsp.cell_data  = rsp_data;

endmodule

`default_nettype wire

@@ rtl/text_console_writer.sv @@
// Text console writer top level: configuration registers, sequencer and screen RAM.
// Depends on tcw_pkg, tcw_ctrl and tcw_screen_ram.
//
// Usage
//   Commands enter on start/req and are taken when start is high and busy low.
//   Each transaction yields one result on rsp, flagged by done for one cycle;
//   the receiver cannot hold it off.
//   Configuration: cfg_we with cfg_index (0 text colour, 1 scroll lines) and
//   cfg_data; write only while the block is idle.
// Timing
//   Put character / line feed: result one cycle after acceptance, and the next
//   command may be taken in that same cycle, so one cycle per character.
//   Read cell: registered RAM read, then ST_READ registers the cell and flags done.
//   Clear screen: one RAM write per cell in the ST_FILL sweep, then done.
//   Scroll (put passing the bottom row): a copy sweep of COLS*(ROWS-d) reads,
//   each written back one entry behind its read, then a fill of the remaining
//   cells, all through the single RAM write port.
// Reset
//   Synchronous rst resets cursor and registers and starts a clearing pass
//   over every cell, during which busy stays high.
`default_nettype none

module text_console_writer #(
  parameter int COLS = tcw_pkg::DEF_COLS,
  parameter int ROWS = tcw_pkg::DEF_ROWS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire tcw_pkg::req_t                     req,
  output logic                                   busy,
  output logic                                   done,
  output tcw_pkg::rsp_t                          rsp,
  input  wire logic                              cfg_we,
  input  wire logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tcw_pkg::CFG_W-1:0]         cfg_data
);

  localparam int CELLS  = COLS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);

  logic [tcw_pkg::COLOR_W-1:0]  text_color;
  logic [tcw_pkg::SCROLL_W-1:0] scroll_lines;

  logic                       mem_we;
  logic [ADDR_W-1:0]          mem_waddr;
  logic [tcw_pkg::CELL_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]          mem_raddr;
  logic [tcw_pkg::CELL_W-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color   <= tcw_pkg::RESET_COLOR;
      scroll_lines <= tcw_pkg::RESET_SCROLL;
    end else if (cfg_we) begin
      case (cfg_index)
        tcw_pkg::REG_TEXT_COLOR:   text_color   <= cfg_data[tcw_pkg::COLOR_W-1:0];
        tcw_pkg::REG_SCROLL_LINES: scroll_lines <= cfg_data[tcw_pkg::SCROLL_W-1:0];
        default: ;
      endcase
    end
  end

  tcw_ctrl #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .req          (req),
    .text_color   (text_color),
    .scroll_lines (scroll_lines),
    .busy         (busy),
    .done         (done),
    .rsp          (rsp),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  tcw_screen_ram #(
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

@@ rtl/tcw_checker.sv @@
// Port-level checks for text_console_writer, attached by bind.
// Depends on tcw_pkg and the top level's ports.
`default_nettype none

module tcw_checker #(
  parameter int COLS = tcw_pkg::DEF_COLS
) (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          start,
  input wire tcw_pkg::req_t req,
  input wire logic          busy,
  input wire logic          done,
  input wire tcw_pkg::rsp_t rsp
);

  // reset starts the clearing pass and drops any pending result
  a_reset_busy: assert property (@(posedge clk) rst |=> busy && !done)
    else $error("reset did not start clearing pass");

  // a read transaction shows busy first, then flags its result on done
  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req.cmd == tcw_pkg::CMD_READ |=> busy ##1 done)
    else $error("read result latency wrong");

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");

  // cursor only moves on an accepted transaction
  a_cursor_hold: assert property (@(posedge clk) disable iff (rst)
    !busy && !start |=> $stable(rsp.cursor_col) && $stable(rsp.cursor_row))
    else $error("cursor moved with no transaction");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    done |-> int'(rsp.cursor_col) < COLS)
    else $error("cursor column out of range");

endmodule

bind text_console_writer tcw_checker #(
  .COLS (COLS)
) u_tcw_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .req   (req),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);

`default_nettype wire

@@ test/text_console_writer_test.sv @@
// Self-checking bench for text_console_writer: random and directed commands
// against a cycle-free screen/cursor predictor held in a small scoreboard class.
// Depends on tcw_pkg and the text_console_writer RTL.
module text_console_writer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS            = tcw_pkg::DEF_COLS;
  localparam int ROWS            = tcw_pkg::DEF_ROWS;
  localparam int CELL_COUNT      = COLS * ROWS;
  localparam int IDX_MAX         = (1 << tcw_pkg::IDX_W) - 1;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 240;
  localparam int TAIL_CYCLES     = 16;
  localparam int WATCHDOG_LIMIT  = 20000;
  localparam int IDLE_PERCENT    = 27;

  localparam logic [1:0] CMD_NONE = 2'd3;  // unused code, block just reports cursor

  class screen_scoreboard;
    logic [tcw_pkg::CELL_W-1:0]   cells [CELL_COUNT];
    int unsigned                  col;
    int unsigned                  row;
    logic [tcw_pkg::COLOR_W-1:0]  colour;
    logic [tcw_pkg::SCROLL_W-1:0] scroll;
    tcw_pkg::rsp_t                expected_q [$];
    int                           errors;

    function new();
      colour = tcw_pkg::RESET_COLOR;
      scroll = tcw_pkg::RESET_SCROLL;
      col    = 0;
      row    = 0;
      errors = 0;
      foreach (cells[i]) cells[i] = tcw_pkg::RESET_CELL;
    endfunction

    function void write_register(logic [tcw_pkg::CFG_IDX_W-1:0] idx,
                                 logic [tcw_pkg::CFG_W-1:0] data);
      if (idx == tcw_pkg::REG_TEXT_COLOR) begin
        colour = data[tcw_pkg::COLOR_W-1:0];
      end else begin
        scroll = data[tcw_pkg::SCROLL_W-1:0];
      end
    endfunction

    function void blank_all();
      foreach (cells[i]) cells[i] = {colour, tcw_pkg::BLANK_CHAR};
    endfunction

    // shift up by the clamped amount, blank the freed rows
    function void scroll_screen();
      int unsigned d;
      d = (scroll == 0) ? 1 : scroll;
      if (d > ROWS) d = ROWS;
      for (int i = 0; i < CELL_COUNT; i++) begin
        if (i < COLS * (ROWS - d)) begin
          cells[i] = cells[i + COLS * d];
        end else begin
          cells[i] = {colour, tcw_pkg::BLANK_CHAR};
        end
      end
      row = ROWS - d;
    endfunction

    function void advance_line();
      col = 0;
      row++;
      if (row >= ROWS) scroll_screen();
    endfunction

    function void note_request(tcw_pkg::req_t r);
      tcw_pkg::rsp_t e;
      e.cell_data = '0;
      case (r.cmd)
        tcw_pkg::CMD_PUT: begin
          if (r.char_code == tcw_pkg::LINE_FEED) begin
            advance_line();
          end else begin
            cells[row * COLS + col] = {colour, r.char_code};
            col++;
            if (col >= COLS) advance_line();
          end
        end
        tcw_pkg::CMD_READ: begin
          if (r.cell_index < CELL_COUNT) e.cell_data = cells[r.cell_index];
        end
        tcw_pkg::CMD_CLEAR: begin
          blank_all();
        end
        default: begin
        end
      endcase
      e.cursor_col = col[tcw_pkg::COLF_W-1:0];
      e.cursor_row = row[tcw_pkg::ROWF_W-1:0];
      expected_q.push_back(e);
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_response(tcw_pkg::rsp_t got);
      tcw_pkg::rsp_t e;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing outstanding (col %0d row %0d data %h)",
                                  got.cursor_col, got.cursor_row, got.cell_data));
        return;
      end
      e = expected_q.pop_front();
      if (got.cursor_col !== e.cursor_col)
        report_mismatch($sformatf("cursor_col %0d, want %0d", got.cursor_col, e.cursor_col));
      if (got.cursor_row !== e.cursor_row)
        report_mismatch($sformatf("cursor_row %0d, want %0d", got.cursor_row, e.cursor_row));
      if (got.cell_data !== e.cell_data)
        report_mismatch($sformatf("cell_data %h, want %h", got.cell_data, e.cell_data));
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          start     = 1'b0;
  tcw_pkg::req_t                 req       = '0;
  logic                          busy;
  logic                          done;
  tcw_pkg::rsp_t                 rsp;
  logic                          cfg_we    = 1'b0;
  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tcw_pkg::CFG_W-1:0]     cfg_data  = '0;

  screen_scoreboard board = new();
  int               sent           = 0;
  int               stalled_cycles = 0;
  bit               steady         = 1'b0;

  text_console_writer i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req),
    .busy      (busy),
    .done      (done),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6ns clk = ~clk;
  end

  // transactions are taken from pre-edge values on both sides
  always @(posedge clk) begin
    if (!rst) begin
      if (done) board.check_response(rsp);
      if (start && !busy) board.note_request(req);
    end
    if (rst || done || (start && !busy) || cfg_we) begin
      stalled_cycles = 0;
    end else begin
      stalled_cycles++;
    end
  end

  initial begin
    wait (stalled_cycles >= WATCHDOG_LIMIT);
    $display("simulation failed");
    $finish;
  end

  function automatic tcw_pkg::req_t make_req(int c, int ch, int idx);
    tcw_pkg::req_t r;
    r.cmd        = 2'(c);
    r.char_code  = tcw_pkg::CHAR_W'(ch);
    r.cell_index = tcw_pkg::IDX_W'(idx);
    return r;
  endfunction

  // mostly cells on the cursor row or just above it, where writes land
  function automatic int pick_cell();
    int pick;
    int r;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      r = board.row;
      if (r > 0 && $urandom_range(0, 1)) r--;
      return r * COLS + int'($urandom_range(0, COLS - 1));
    end else if (pick < 85) begin
      return int'($urandom_range(0, CELL_COUNT - 1));
    end
    return int'($urandom_range(CELL_COUNT, IDX_MAX));
  endfunction

  task automatic send(input tcw_pkg::req_t r);
    if (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (board.pending() != 0 || busy);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic program_registers(input logic [tcw_pkg::CFG_W-1:0] colour_val,
                                   input logic [tcw_pkg::CFG_W-1:0] scroll_val);
    cfg_we    <= 1'b1;
    cfg_index <= tcw_pkg::REG_TEXT_COLOR;
    cfg_data  <= colour_val;
    @(posedge clk);
    board.write_register(tcw_pkg::REG_TEXT_COLOR, colour_val);
    cfg_index <= tcw_pkg::REG_SCROLL_LINES;
    cfg_data  <= scroll_val;
    @(posedge clk);
    board.write_register(tcw_pkg::REG_SCROLL_LINES, scroll_val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // bursts: short text lines ending in a line feed, reads of nearby cells,
  // the odd clear and the odd fully random command
  task automatic run_random(input int n);
    int first;
    int pick;
    int len;
    first = sent;
    while (sent - first < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(80, 170) : $urandom_range(0, 4);
        repeat (len) send(make_req(tcw_pkg::CMD_PUT, $urandom_range(0, 255),
                                   $urandom_range(0, IDX_MAX)));
        send(make_req(tcw_pkg::CMD_PUT, tcw_pkg::LINE_FEED, $urandom_range(0, IDX_MAX)));
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 4))
          send(make_req(tcw_pkg::CMD_READ, $urandom_range(0, 255), pick_cell()));
      end else if (pick < 93) begin
        send(make_req(tcw_pkg::CMD_CLEAR, $urandom_range(0, 255), $urandom_range(0, IDX_MAX)));
      end else begin
        send(make_req($urandom_range(0, 3), $urandom_range(0, 255), $urandom_range(0, IDX_MAX)));
      end
    end
  endtask

  initial begin
    logic [tcw_pkg::CFG_W-1:0] colour_val;
    logic [tcw_pkg::CFG_W-1:0] scroll_val;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);
    wait_idle();  // clearing pass after reset

    // directed: reset contents, index extremes, char extremes, line feeds,
    // unused command, clear
    send(make_req(tcw_pkg::CMD_READ, 8'h00, 0));
    send(make_req(tcw_pkg::CMD_READ, 8'hFF, CELL_COUNT - 1));
    send(make_req(tcw_pkg::CMD_READ, 8'h00, CELL_COUNT));
    send(make_req(tcw_pkg::CMD_READ, 8'h00, IDX_MAX));
    send(make_req(tcw_pkg::CMD_PUT, 8'h00, IDX_MAX));
    send(make_req(tcw_pkg::CMD_PUT, 8'hFF, 0));
    send(make_req(tcw_pkg::CMD_PUT, 8'h41, 0));
    send(make_req(tcw_pkg::CMD_PUT, tcw_pkg::LINE_FEED, 0));
    send(make_req(tcw_pkg::CMD_PUT, tcw_pkg::LINE_FEED, 0));
    send(make_req(tcw_pkg::CMD_READ, 8'h00, 0));
    send(make_req(tcw_pkg::CMD_READ, 8'h00, 1));
    send(make_req(tcw_pkg::CMD_READ, 8'h00, 2));
    send(make_req(tcw_pkg::CMD_READ, 8'h00, COLS));
    send(make_req(CMD_NONE, 8'hFF, IDX_MAX));
    send(make_req(tcw_pkg::CMD_CLEAR, 8'h00, 0));
    send(make_req(tcw_pkg::CMD_READ, 8'h00, 0));
    send(make_req(tcw_pkg::CMD_READ, 8'h00, CELL_COUNT - 1));
    send(make_req(tcw_pkg::CMD_PUT, 8'h5A, 0));
    send(make_req(tcw_pkg::CMD_READ, 8'h00, 2 * COLS));

    // scroll order keeps the cursor low so the large scrolls get exercised
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0: begin
          colour_val = 8'h00;
          scroll_val = 8'h01;
        end
        1: begin
          colour_val = 8'hFF;
          scroll_val = 8'hE0;  // zero lines, upper data bits set
        end
        2: begin
          colour_val = tcw_pkg::CFG_W'($urandom_range(0, 255));
          scroll_val = tcw_pkg::CFG_W'(ROWS);
        end
        3: begin
          colour_val = 8'h5A;
          scroll_val = 8'hFF;  // 31, beyond the screen height
        end
        4: begin
          colour_val = tcw_pkg::CFG_W'($urandom_range(0, 255));
          scroll_val = {3'($urandom_range(0, 7)), 5'($urandom_range(2, ROWS - 1))};
        end
        default: begin
          colour_val = tcw_pkg::CFG_W'($urandom_range(0, 255));
          scroll_val = 8'h01;
        end
      endcase
      program_registers(colour_val, scroll_val);
      steady = (p == 3);
      run_random(ITEMS_PER_PHASE);
    end

    wait_idle();
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
